FILE: sv/i2c_master_byte_sequencer_defines.svh
// Assertion macros for the I2C master byte sequencer.
// Included by i2cm_seq, the RTL file that carries concurrent checks; depends on clk and rst.
`ifndef I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_BYTE_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS
`define I2CM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cm check failed");
`define I2CM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cm check failed");
`else
`define I2CM_ASSERT_IMP(lbl, ante, cons)
`define I2CM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: sv/i2cm_pkg.sv
// Shared types and constants for the I2C master byte sequencer.
// No dependencies; used by the sequencer, the result register and the top level.
package i2cm_pkg;

  localparam int PHASE_W = 5;

  typedef enum logic [3:0] {
    CMD_TICK      = 4'd0,
    CMD_START     = 4'd1,
    CMD_STOP      = 4'd2,
    CMD_ACK       = 4'd3,
    CMD_NACK      = 4'd4,
    CMD_WAIT_ACK  = 4'd5,
    CMD_WRITE     = 4'd6,
    CMD_READ      = 4'd7,
    CMD_BUS_RESET = 4'd8
  } cmd_t;

  localparam logic [15:0]        HALF_PERIOD_RESET = 16'd4;
  localparam logic [PHASE_W-1:0] WRITE_LAST_PHASE  = 5'd21;
  localparam logic [PHASE_W-1:0] WRITE_END_PHASE   = 5'd23;
  localparam logic [PHASE_W-1:0] READ_LAST_PHASE   = 5'd14;
  localparam logic [PHASE_W-1:0] READ_END_PHASE    = 5'd15;

  localparam logic [1:0] BIT_STEP_LOW   = 2'd0;
  localparam logic [1:0] BIT_STEP_HIGH  = 2'd1;
  localparam logic [1:0] BIT_STEP_SHIFT = 2'd2;

  // step within a written bit for each phase index
  localparam logic [1:0] WRITE_STEP [32] = '{
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
    2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
    2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
    2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1
  };

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte_out;
    logic       nack_seen;
    logic       rejected;
  } res_t;

endpackage

FILE: sv/i2cm_seq.sv
// Command and phase sequencer: holds the bus state and works out each item's result.
// Depends on i2cm_pkg and the assertion macros header.
`include "i2c_master_byte_sequencer_defines.svh"

module i2cm_seq #(
  parameter int DELAY_WIDTH = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  logic [3:0]    operation,
  input  logic [7:0]    write_data,
  input  logic          sda_in,
  input  logic [15:0]   half_period,
  output i2cm_pkg::res_t result
);
  import i2cm_pkg::*;

  cmd_t                   command, command_next;
  logic [PHASE_W-1:0]     phase, phase_next;
  logic [DELAY_WIDTH-1:0] delay_count, delay_next;
  logic [7:0]             shift_byte, shift_next;
  logic                   scl_reg, scl_next;
  logic                   sda_reg, sda_next;
  logic                   ack_reg, ack_next;
  logic [7:0]             read_reg, read_next;

  logic                   is_cmd;
  cmd_t                   op_cmd;
  logic [DELAY_WIDTH-1:0] hp_trim, arm_value, delay_dec;
  logic                   fin, reject;

  assign is_cmd    = (operation >= 4'd1) && (operation <= 4'd8);
  assign op_cmd    = is_cmd ? cmd_t'(operation) : CMD_TICK;
  assign hp_trim   = DELAY_WIDTH'(half_period);
  assign arm_value = (hp_trim == '0) ? DELAY_WIDTH'(1) : hp_trim;
  assign delay_dec = delay_count - DELAY_WIDTH'(1);

  always_comb begin
    command_next = command;
    phase_next   = phase;
    delay_next   = delay_count;
    shift_next   = shift_byte;
    scl_next     = scl_reg;
    sda_next     = sda_reg;
    ack_next     = ack_reg;
    read_next    = read_reg;
    fin          = 1'b0;
    reject       = 1'b0;
    if (accept && is_cmd) begin
      if (command != CMD_TICK) begin
        reject = 1'b1;
      end else begin
        command_next = op_cmd;
        phase_next   = '0;
        delay_next   = arm_value;
        unique case (op_cmd)
          CMD_START, CMD_NACK, CMD_WAIT_ACK, CMD_BUS_RESET: begin
            scl_next = 1'b1;
            sda_next = 1'b1;
          end
          CMD_STOP, CMD_ACK: begin
            scl_next = 1'b1;
            sda_next = 1'b0;
          end
          CMD_WRITE: begin
            shift_next = write_data;
            sda_next   = write_data[7];
          end
          CMD_READ: begin
            shift_next = '0;
            scl_next   = 1'b1;
          end
          default: ;
        endcase
      end
    end else if (accept && command != CMD_TICK) begin
      delay_next = delay_dec;
      if (delay_dec == '0) begin
        unique case (command)
          CMD_START, CMD_BUS_RESET: begin
            if (phase == '0) begin
              sda_next = 1'b0;
            end else begin
              scl_next = 1'b0;
              fin      = 1'b1;
            end
          end
          CMD_STOP: begin
            sda_next = 1'b1;
            fin      = 1'b1;
          end
          CMD_ACK: begin
            if (phase == 5'd0) begin
              scl_next = 1'b0;
            end else if (phase == 5'd1) begin
              sda_next = 1'b1;
            end else begin
              fin = 1'b1;
            end
          end
          CMD_NACK: begin
            if (phase == '0) scl_next = 1'b0;
            else fin = 1'b1;
          end
          CMD_WAIT_ACK: begin
            if (phase == '0) begin
              ack_next = sda_in;
              scl_next = 1'b0;
            end else begin
              fin = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (WRITE_STEP[phase] == BIT_STEP_LOW) begin
              scl_next = 1'b1;
            end else if (WRITE_STEP[phase] == BIT_STEP_HIGH) begin
              scl_next = 1'b0;
            end else if (phase >= WRITE_LAST_PHASE) begin
              sda_next = 1'b1;
              fin      = 1'b1;
            end else begin
              shift_next = {shift_byte[6:0], 1'b0};
              sda_next   = shift_byte[6];
            end
          end
          CMD_READ: begin
            if (!phase[0]) begin
              shift_next = {shift_byte[6:0], sda_in};
              scl_next   = 1'b0;
            end else if (phase >= READ_LAST_PHASE) begin
              read_next = shift_byte;
              fin       = 1'b1;
            end else begin
              scl_next = 1'b1;
            end
          end
          default: fin = 1'b1;
        endcase
        if (fin) begin
          command_next = CMD_TICK;
          phase_next   = '0;
          delay_next   = '0;
        end else begin
          phase_next = phase + 5'd1;
          delay_next = arm_value;
        end
      end
    end
  end

  always_comb begin
    result.scl_level     = scl_next;
    result.sda_level     = sda_next;
    result.busy_res      = (command_next != CMD_TICK);
    result.done_res      = fin;
    result.read_byte_out = read_next;
    result.nack_seen     = ack_next;
    result.rejected      = reject;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command     <= CMD_TICK;
      phase       <= '0;
      delay_count <= '0;
      shift_byte  <= '0;
      scl_reg     <= 1'b1;
      sda_reg     <= 1'b1;
      ack_reg     <= 1'b0;
      read_reg    <= '0;
    end else begin
      command     <= command_next;
      phase       <= phase_next;
      delay_count <= delay_next;
      shift_byte  <= shift_next;
      scl_reg     <= scl_next;
      sda_reg     <= sda_next;
      ack_reg     <= ack_next;
      read_reg    <= read_next;
    end
  end

  `I2CM_ASSERT_IMP(a_delay_armed, command != CMD_TICK, delay_count != '0)
  `I2CM_ASSERT_NEXT(a_cmd_taken, accept && is_cmd && command == CMD_TICK, command == $past(op_cmd))
  `I2CM_ASSERT_NEXT(a_reject_holds, accept && is_cmd && command != CMD_TICK, $stable(command) && $stable(phase))
  `I2CM_ASSERT_IMP(a_write_phase, command == CMD_WRITE, phase <= WRITE_END_PHASE)
  `I2CM_ASSERT_IMP(a_read_phase, command == CMD_READ, phase <= READ_END_PHASE)

endmodule

FILE: sv/i2cm_out_reg.sv
// Result register with valid and ready: holds one result item until taken.
// Depends on i2cm_pkg for the result type.
module i2cm_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  i2cm_pkg::res_t data_in,
  input  logic           out_ready,
  output logic           out_valid,
  output logic           can_load,
  output i2cm_pkg::res_t data_out
);
  import i2cm_pkg::*;

  res_t held;
  logic valid;

  assign can_load  = !valid || out_ready;
  assign out_valid = valid;
  assign data_out  = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= data_in;
    end
  end

endmodule

FILE: sv/i2c_master_byte_sequencer.sv
// I2C master byte sequencer: one result item per input item, offered the next cycle.
// One item per clock while out_ready holds; the register frees as its result is taken.
// Bus phases are counted in tick items, half_period ticks per phase (0 acts as 1).
// Synchronous reset: idle, SCL and SDA released, half_period back to 4, no result held.
// Depends on i2cm_pkg, i2cm_seq and i2cm_out_reg.
module i2c_master_byte_sequencer #(
  parameter int DELAY_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  operation,
  input  logic [7:0]  write_data,
  input  logic        sda_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        scl_level,
  output logic        sda_level,
  output logic        busy_res,
  output logic        done_res,
  output logic [7:0]  read_byte_out,
  output logic        nack_seen,
  output logic        rejected
);
  import i2cm_pkg::*;

  logic [15:0] half_period;
  logic        accept;
  res_t        result_next, result;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period <= HALF_PERIOD_RESET;
    end else if (cfg_write_enable) begin
      half_period <= cfg_write_data;
    end
  end

  assign accept = in_valid && in_ready;

  i2cm_seq #(
    .DELAY_WIDTH(DELAY_WIDTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .operation  (operation),
    .write_data (write_data),
    .sda_in     (sda_in),
    .half_period(half_period),
    .result     (result_next)
  );

  i2cm_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (accept),
    .data_in  (result_next),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .can_load (in_ready),
    .data_out (result)
  );

  assign scl_level     = result.scl_level;
  assign sda_level     = result.sda_level;
  assign busy_res      = result.busy_res;
  assign done_res      = result.done_res;
  assign read_byte_out = result.read_byte_out;
  assign nack_seen     = result.nack_seen;
  assign rejected      = result.rejected;

endmodule
